// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while in reset.
`define CHK_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");

// Next-cycle implication, off while in reset.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/mjsi_pkg.sv -----
package mjsi_pkg;
  localparam int REQ_W = 2;
  localparam int ID_W  = 4;
  localparam int POS_W = 16;
  localparam int MS_W  = 16;

  localparam int SERVO_COUNT = 11;

  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MOVE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PRESET = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [MS_W-1:0] MS_MAX = 16'hFFFF;
endpackage

// ----- rtl/mjsi_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Needs dividend < divisor; returns floor(dividend * 2^FRAC_BITS / divisor).
module mjsi_div import mjsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [MS_W-1:0]      dividend,
  input  logic [MS_W-1:0]      divisor,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quot
);
  localparam int CW = $clog2(FRAC_BITS + 1);

  logic [MS_W:0]          rem_r;
  logic [MS_W-1:0]        dvs_r;
  logic [FRAC_BITS-1:0]   q_r;
  logic [CW-1:0]          cnt_r;
  logic                   run_r;
  logic                   done_r;
  logic [MS_W:0]          shl;
  logic                   ge;
  logic [MS_W:0]          rem_nxt;

  assign shl     = {rem_r[MS_W-1:0], 1'b0};
  assign ge      = shl >= {1'b0, dvs_r};
  assign rem_nxt = ge ? (shl - {1'b0, dvs_r}) : shl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rem_r <= {1'b0, dividend};
        dvs_r <= divisor;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[FRAC_BITS-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(FRAC_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ----- rtl/mjsi_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle (unsigned).
module mjsi_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] a_r;
  logic [PW-1:0] p_r;
  logic [BW-1:0] b_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        a_r   <= PW'(a);
        b_r   <= b;
        p_r   <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (b_r[0]) p_r <= p_r + a_r;
        a_r   <= {a_r[PW-2:0], 1'b0};
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;
endmodule

// ----- rtl/min_jerk_servo_interpolator_top.sv -----
// A move holds busy for the S_MOVE state only, a preset or ignored command not at all; a tick
// scans each servo, where an idle or snapping one is handled in S_SCAN and an interpolating one
// runs the bit-serial divider and then the multiplier for tau^2 to tau^5 and the scaling, then
// walks every index up to the last moved servo to report (a single empty report if none moved).
// Throughput: one transaction at a time; busy stays high until the last result is out.
// Results strobed by out_valid, no stall; reset (rst_n low, sync) zeroes servo state.
module min_jerk_servo_interpolator_top import mjsi_pkg::*; #(
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [ID_W-1:0]         in_servo_sel,
  input  logic signed [POS_W-1:0] in_goal_position,
  input  logic [MS_W-1:0]         in_move_ms,
  output logic                    out_valid,
  output logic [ID_W-1:0]         out_servo_id,
  output logic signed [POS_W-1:0] out_position,
  output logic                    out_position_valid,
  output logic                    out_all_done,
  output logic                    out_last_of_run
);
`include "assert_macros.svh"

  localparam int F   = FRAC_BITS;
  localparam int SC  = SERVO_COUNT;
  localparam int IW  = (SC > 1) ? $clog2(SC) : 1;
  localparam int AW  = (F > POS_W + 1) ? F : POS_W + 1;  // multiplicand: tau power or |delta|
  localparam int BW  = F + 1;                             // multiplier: tau or clamped s
  localparam int PW  = AW + BW;
  localparam int SPW = F + 6;                             // room for 10*t3 + 6*t5

  typedef enum logic [3:0] {
    S_IDLE, S_MOVE, S_SCAN, S_DIV, S_T2, S_T3, S_T4, S_T5, S_SCALE, S_EMIT
  } state_t;

  state_t state_r;

  // Per-servo state; every read goes through the sequencer index idx_r.
  logic [POS_W-1:0] start_pos_r  [SC];
  logic [POS_W-1:0] goal_pos_r   [SC];
  logic [POS_W-1:0] now_pos_r    [SC];
  logic [MS_W-1:0]  span_ms_r    [SC];
  logic [MS_W-1:0]  elapsed_ms_r [SC];

  logic [IW-1:0]    idx_r;
  logic [SC-1:0]    moved_r;      // servos that changed on this tick
  logic             busy_run_r;   // some servo still interpolating
  logic [POS_W-1:0] goal_hold_r;  // move operands held for the S_MOVE cycle
  logic [MS_W-1:0]  ms_hold_r;
  logic [F-1:0]     tau_r, t3_r, t4_r;

  logic             div_go_r, mul_go_r;
  logic [MS_W-1:0]  div_num_r, div_den_r;
  logic [AW-1:0]    mul_a_r;
  logic [BW-1:0]    mul_b_r;
  logic             div_done, mul_done;
  logic [F-1:0]     div_q;
  logic [PW-1:0]    mul_p;

  logic                   out_valid_r, out_pv_r, out_done_r, out_last_r;
  logic [ID_W-1:0]        out_id_r;
  logic [POS_W-1:0]       out_pos_r;

  mjsi_div #(.FRAC_BITS(F)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go_r), .dividend(div_num_r), .divisor(div_den_r),
    .done(div_done), .quot(div_q)
  );

  mjsi_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go_r), .a(mul_a_r), .b(mul_b_r),
    .done(mul_done), .prod(mul_p)
  );

  // Combinational views of the command and of the indexed servo.
  logic              accept;
  logic [IW-1:0]     sel_idx;
  logic              sel_ok;
  logic              last_idx;
  logic [MS_W-1:0]   el_inc;
  logic [F-1:0]      t_cur;        // product >> F for tau powers
  logic signed [SPW-1:0] s_poly;
  logic [F:0]        s_clamp;
  logic signed [POS_W:0] delta;
  logic              delta_neg;
  logic [POS_W:0]    delta_mag;
  logic [POS_W:0]    scaled;       // |delta| * s >> F, truncation toward zero
  logic [POS_W:0]    signed_step;
  logic [POS_W-1:0]  pos_new;
  logic [SC-1:0]     moved_rest;

  assign accept   = start && !busy;
  assign sel_idx  = IW'(in_servo_sel);
  assign sel_ok   = 32'(in_servo_sel) < 32'(SC);
  assign last_idx = idx_r == IW'(SC - 1);
  assign el_inc   = (elapsed_ms_r[idx_r] == MS_MAX) ? MS_MAX : elapsed_ms_r[idx_r] + 1'b1;
  assign t_cur    = mul_p[2*F-1:F];

  // s = 10*t3 - 15*t4 + 6*t5 with t5 taken straight from the multiplier.
  assign s_poly = $signed(SPW'(t3_r) << 3) + $signed(SPW'(t3_r) << 1)
                - ($signed(SPW'(t4_r) << 4) - $signed(SPW'(t4_r)))
                + $signed(SPW'(t_cur) << 2) + $signed(SPW'(t_cur) << 1);
  always_comb begin
    if (s_poly < 0) s_clamp = '0;
    else if (s_poly > $signed(SPW'(1) << F)) s_clamp = (F+1)'(1) << F;
    else s_clamp = s_poly[F:0];
  end

  assign delta       = $signed({goal_pos_r[idx_r][POS_W-1], goal_pos_r[idx_r]})
                     - $signed({start_pos_r[idx_r][POS_W-1], start_pos_r[idx_r]});
  assign delta_neg   = delta[POS_W];
  assign delta_mag   = delta_neg ? (POS_W+1)'(-delta) : delta;
  assign scaled      = mul_p[F+POS_W:F];
  assign signed_step = delta_neg ? ((POS_W+1)'(0) - scaled) : scaled;
  assign pos_new     = start_pos_r[idx_r] + signed_step[POS_W-1:0];
  assign moved_rest  = moved_r >> idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      moved_r     <= '0;
      busy_run_r  <= 1'b0;
      div_go_r    <= 1'b0;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SC; i++) begin
        start_pos_r[i]  <= '0;
        goal_pos_r[i]   <= '0;
        now_pos_r[i]    <= '0;
        span_ms_r[i]    <= '0;
        elapsed_ms_r[i] <= '0;
      end
    end else begin
      div_go_r    <= 1'b0;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_req_type == REQ_TICK) begin
              idx_r      <= '0;
              moved_r    <= '0;
              busy_run_r <= 1'b0;
              state_r    <= S_SCAN;
            end else if (in_req_type == REQ_MOVE && sel_ok) begin
              idx_r       <= sel_idx;
              goal_hold_r <= in_goal_position;
              ms_hold_r   <= in_move_ms;
              state_r     <= S_MOVE;
            end else if (in_req_type == REQ_PRESET && sel_ok) begin
              start_pos_r[sel_idx]  <= in_goal_position;
              goal_pos_r[sel_idx]   <= in_goal_position;
              now_pos_r[sel_idx]    <= in_goal_position;
              span_ms_r[sel_idx]    <= '0;
              elapsed_ms_r[sel_idx] <= '0;
            end
          end
        end
        S_MOVE: begin
          start_pos_r[idx_r]  <= now_pos_r[idx_r];
          goal_pos_r[idx_r]   <= goal_hold_r;
          span_ms_r[idx_r]    <= ms_hold_r;
          elapsed_ms_r[idx_r] <= '0;
          state_r             <= S_IDLE;
        end
        S_SCAN: begin
          if (now_pos_r[idx_r] != goal_pos_r[idx_r]) begin
            elapsed_ms_r[idx_r] <= el_inc;
            moved_r[idx_r]      <= 1'b1;
            if (el_inc >= span_ms_r[idx_r]) begin
              now_pos_r[idx_r] <= goal_pos_r[idx_r];
            end else begin
              div_num_r <= el_inc;
              div_den_r <= span_ms_r[idx_r];
              div_go_r  <= 1'b1;
              state_r   <= S_DIV;
            end
          end
          // advance unless an interpolation was launched
          if (!(now_pos_r[idx_r] != goal_pos_r[idx_r] && el_inc < span_ms_r[idx_r])) begin
            if (last_idx) begin
              idx_r   <= '0;
              state_r <= S_EMIT;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            tau_r    <= div_q;
            mul_a_r  <= AW'(div_q);
            mul_b_r  <= BW'(div_q);
            mul_go_r <= 1'b1;
            state_r  <= S_T2;
          end
        end
        S_T2: begin
          if (mul_done) begin
            mul_a_r  <= AW'(t_cur);
            mul_b_r  <= BW'(tau_r);
            mul_go_r <= 1'b1;
            state_r  <= S_T3;
          end
        end
        S_T3: begin
          if (mul_done) begin
            t3_r     <= t_cur;
            mul_a_r  <= AW'(t_cur);
            mul_b_r  <= BW'(tau_r);
            mul_go_r <= 1'b1;
            state_r  <= S_T4;
          end
        end
        S_T4: begin
          if (mul_done) begin
            t4_r     <= t_cur;
            mul_a_r  <= AW'(t_cur);
            mul_b_r  <= BW'(tau_r);
            mul_go_r <= 1'b1;
            state_r  <= S_T5;
          end
        end
        S_T5: begin
          if (mul_done) begin
            mul_a_r  <= AW'(delta_mag);
            mul_b_r  <= s_clamp;
            mul_go_r <= 1'b1;
            state_r  <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (mul_done) begin
            now_pos_r[idx_r] <= pos_new;
            busy_run_r       <= 1'b1;
            if (last_idx) begin
              idx_r   <= '0;
              state_r <= S_EMIT;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_SCAN;
            end
          end
        end
        S_EMIT: begin
          if (moved_r == '0) begin
            // nothing moved: single empty report
            out_valid_r <= 1'b1;
            out_id_r    <= '0;
            out_pos_r   <= '0;
            out_pv_r    <= 1'b0;
            out_done_r  <= 1'b1;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            if (moved_r[idx_r]) begin
              out_valid_r <= 1'b1;
              out_id_r    <= ID_W'(idx_r);
              out_pos_r   <= now_pos_r[idx_r];
              out_pv_r    <= 1'b1;
              out_done_r  <= !busy_run_r;
              out_last_r  <= moved_rest == SC'(1);
            end
            if (moved_rest == SC'(1)) state_r <= S_IDLE;
            else idx_r <= idx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_servo_id       = out_id_r;
  assign out_position       = out_pos_r;
  assign out_position_valid = out_pv_r;
  assign out_all_done       = out_done_r;
  assign out_last_of_run    = out_last_r;

  // After an accepted tick the sequencer is busy in the next cycle.
  `CHK_NEXT(a_tick_busy, clk, rst_n, accept && in_req_type == REQ_TICK, busy)
  // More results of a run still to come means the sequencer is still working.
  `CHK_IMPL(a_run_busy, clk, rst_n, out_valid && !out_last_of_run, busy)
  // The empty report is the only and final one, and reports completion.
  `CHK_IMPL(a_empty_rep, clk, rst_n, out_valid && !out_position_valid,
            out_all_done && out_last_of_run)
endmodule

// ----- tb/sv/mjsi_checker.sv -----
`timescale 1ns / 1ps

module mjsi_checker import mjsi_pkg::*; #(
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [ID_W-1:0]         in_servo_sel,
  input  logic signed [POS_W-1:0] in_goal_position,
  input  logic [MS_W-1:0]         in_move_ms,
  input  logic                    out_valid,
  input  logic [ID_W-1:0]         out_servo_id,
  input  logic signed [POS_W-1:0] out_position,
  input  logic                    out_position_valid,
  input  logic                    out_all_done,
  input  logic                    out_last_of_run,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] pos;
    logic                    pv;
    logic                    done;
    logic                    last;
  } servo_report_t;

  servo_report_t report_q[$];

  logic signed [POS_W-1:0] origin_pos [SERVO_COUNT];
  logic signed [POS_W-1:0] target_pos [SERVO_COUNT];
  logic signed [POS_W-1:0] cur_pos    [SERVO_COUNT];
  logic [MS_W-1:0]         span       [SERVO_COUNT];
  logic [MS_W-1:0]         age        [SERVO_COUNT];

  assign pending = report_q.size();

  // Quintic min-jerk blend from the move's origin.
  function automatic logic signed [POS_W-1:0] quintic_pos(int k);
    longint unsigned unity, tau, t2, t3, t4, t5;
    longint s, delta, prod;
    unity = 64'd1 << FRAC_BITS;
    tau = (longint'(age[k]) << FRAC_BITS) / longint'(span[k]);
    t2 = (tau * tau) >> FRAC_BITS;
    t3 = (t2 * tau) >> FRAC_BITS;
    t4 = (t3 * tau) >> FRAC_BITS;
    t5 = (t4 * tau) >> FRAC_BITS;
    s = 10 * longint'(t3) - 15 * longint'(t4) + 6 * longint'(t5);
    if (s < 0) s = 0;
    if (s > longint'(unity)) s = longint'(unity);
    delta = longint'(target_pos[k]) - longint'(origin_pos[k]);
    prod = delta * s;
    return POS_W'(longint'(origin_pos[k]) + prod / longint'(unity));
  endfunction

  task automatic run_tick();
    servo_report_t tick_q[$];
    servo_report_t r;
    bit moving;
    moving = 0;
    for (int k = 0; k < SERVO_COUNT; k++) begin
      if (cur_pos[k] == target_pos[k]) continue;
      if (age[k] != MS_MAX) age[k]++;
      if (age[k] >= span[k]) begin
        cur_pos[k] = target_pos[k];
      end else begin
        cur_pos[k] = quintic_pos(k);
        moving = 1;
      end
      r = '{id: ID_W'(k), pos: cur_pos[k], pv: 1'b1, done: 1'b0, last: 1'b0};
      tick_q = {tick_q, r};
    end
    if (tick_q.size() == 0) begin
      r = '{id: '0, pos: '0, pv: 1'b0, done: 1'b1, last: 1'b1};
      report_q = {report_q, r};
    end else begin
      foreach (tick_q[j]) begin
        tick_q[j].done = !moving;
        tick_q[j].last = (j == tick_q.size() - 1);
        report_q = {report_q, tick_q[j]};
      end
    end
  endtask

  always @(posedge clk) begin
    servo_report_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      report_q.delete();
      for (int k = 0; k < SERVO_COUNT; k++) begin
        origin_pos[k] = '0; target_pos[k] = '0; cur_pos[k] = '0;
        span[k] = '0; age[k] = '0;
      end
    end else begin
      if (out_valid) begin
        if (report_q.size() == 0) begin
          $error("unexpected result: id %0d pos %0d", out_servo_id, out_position);
          errs++;
        end else begin
          e = report_q.pop_front();
          if (e.id !== out_servo_id) begin
            $error("servo_id exp %0d got %0d", e.id, out_servo_id);
            errs++;
          end
          if (e.pos !== out_position) begin
            $error("position exp %0d got %0d", e.pos, out_position);
            errs++;
          end
          if (e.pv !== out_position_valid) begin
            $error("position_valid exp %0d got %0d", e.pv, out_position_valid);
            errs++;
          end
          if (e.done !== out_all_done) begin
            $error("all_done exp %0d got %0d", e.done, out_all_done);
            errs++;
          end
          if (e.last !== out_last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last, out_last_of_run);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (start && !busy) begin
        if (in_req_type == REQ_TICK) begin
          run_tick();
        end else if ((in_req_type == REQ_MOVE || in_req_type == REQ_PRESET) &&
                     in_servo_sel < SERVO_COUNT) begin
          if (in_req_type == REQ_MOVE) begin
            origin_pos[in_servo_sel] = cur_pos[in_servo_sel];
            target_pos[in_servo_sel] = in_goal_position;
            span[in_servo_sel] = in_move_ms;
          end else begin
            origin_pos[in_servo_sel] = in_goal_position;
            target_pos[in_servo_sel] = in_goal_position;
            cur_pos[in_servo_sel] = in_goal_position;
            span[in_servo_sel] = '0;
          end
          age[in_servo_sel] = '0;
        end
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mjsi_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [REQ_W-1:0]        in_req_type;
  logic [ID_W-1:0]         in_servo_sel;
  logic signed [POS_W-1:0] in_goal_position;
  logic [MS_W-1:0]         in_move_ms;
  logic                    out_valid;
  logic [ID_W-1:0]         out_servo_id;
  logic signed [POS_W-1:0] out_position;
  logic                    out_position_valid;
  logic                    out_all_done;
  logic                    out_last_of_run;
  int                      fail_count;
  int                      pending;
  int                      idle_pct;

  min_jerk_servo_interpolator_top dut (.*);

  // Scoreboard sits beside the block and watches both channels.
  mjsi_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the worst tick has all 11 servos interpolating.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Issue one command transaction; optional random idle cycles ahead of it.
  // start stays high after acceptance until the next command or a drain.
  task automatic send_cmd(logic [REQ_W-1:0] rq, logic [ID_W-1:0] sel,
                          logic signed [POS_W-1:0] gp, logic [MS_W-1:0] ms);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    start            <= 1'b1;
    in_req_type      <= rq;
    in_servo_sel     <= sel;
    in_goal_position <= gp;
    in_move_ms       <= ms;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start and wait until every expected result has come.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic tick();
    send_cmd(REQ_TICK, ID_W'($urandom), POS_W'($urandom), MS_W'($urandom));
  endtask

  // Mostly short moves on valid servos, ticked through; some noise commands.
  task automatic random_item();
    int pick;
    logic [ID_W-1:0] sel;
    logic [MS_W-1:0] ms;
    pick = $urandom_range(99);
    sel = ID_W'($urandom_range(10));
    if ($urandom_range(15) == 0) sel = ID_W'($urandom_range(15, 11));
    ms = MS_W'($urandom_range(12));
    if ($urandom_range(40) == 0) ms = MS_W'($urandom);
    if (pick < 45)       tick();
    else if (pick < 80)  send_cmd(REQ_MOVE, sel, POS_W'($urandom), ms);
    else if (pick < 92)  send_cmd(REQ_PRESET, sel, POS_W'($urandom), MS_W'($urandom));
    else                 send_cmd(REQ_UNUSED, ID_W'($urandom), POS_W'($urandom),
                                  MS_W'($urandom));
  endtask

  initial begin
    int wait_cyc;
    rst_n = 0; start = 0; idle_pct = 0;
    in_req_type = REQ_TICK; in_servo_sel = '0; in_goal_position = '0; in_move_ms = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle tick, extremes of position, zero span, long span, bad index.
    tick();
    send_cmd(REQ_MOVE, 4'd0, 16'sh7FFF, 16'd5);
    send_cmd(REQ_MOVE, 4'd10, -16'sd32768, 16'd3);
    send_cmd(REQ_MOVE, 4'd5, 16'sd100, 16'd0);
    send_cmd(REQ_MOVE, 4'd15, 16'sd1, 16'd4);
    send_cmd(REQ_PRESET, 4'd11, 16'sd7, 16'hFFFF);
    send_cmd(REQ_UNUSED, 4'hF, 16'shFFFF, 16'hFFFF);
    repeat (6) tick();
    send_cmd(REQ_PRESET, 4'd3, -16'sd1, 16'd9);
    send_cmd(REQ_MOVE, 4'd3, 16'sd32767, 16'hFFFF);
    repeat (3) tick();
    send_cmd(REQ_PRESET, 4'd3, 16'sd0, 16'd0);
    tick();
    tick();

    // Random phases: no idling, heavy idling, a lighter mix, and no idling again.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 48 : (ph == 2) ? 10 : 0;
      for (int n = 0; n < 90; n++) random_item();
      // Pause until the scoreboard has drained once per phase.
      drain();
    end

    wait_cyc = 0;
    while (pending != 0 && wait_cyc < 5000) begin
      @(negedge clk);
      wait_cyc++;
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
